// ===== rtl/ssprx_pkg.sv =====
// Shared constants for the servo status packet receiver: op, status and
// register codes, field widths and register reset values. No dependencies.
package ssprx_pkg;

    localparam int MAX_PAYLOAD_DEF = 16;

    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int ID_W     = 8;
    localparam int PLEN_W   = 5;
    localparam int TICK_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CHECKSUM = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

    localparam logic [ID_W-1:0]   EXPECTED_ID_RST   = 8'd1;
    localparam logic [PLEN_W-1:0] PAYLOAD_LEN_RST   = 5'd2;
    localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd1000;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

endpackage

// ===== rtl/servo_status_packet_receiver_core.sv =====
// Servo status frame receiver: the parser takes one item per cycle while s_tready
// is high; it stalls while the job queue is full or a good frame is emitted. A
// status item passes via the job queue to the output register; a good frame reads
// its payload bytes one by one from the registered payload RAM into the output
// register, and input stalls until the last is presented. Synchronous active-low
// reset idles the receiver and restores register defaults; the payload RAM is kept.
module servo_status_packet_receiver_core #(
    parameter int MAX_PAYLOAD = ssprx_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] byte_in
    input  logic [ssprx_pkg::OP_W-1:0]        s_tuser,   // [1:0] op
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] data_byte
    output logic [ssprx_pkg::STATUS_W-1:0]    m_tuser,   // [1:0] status
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ssprx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ssprx_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import ssprx_pkg::*;

    localparam int LW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int JW = STATUS_W + LW;

    logic [ID_W-1:0]     expected_id_reg;
    logic [PLEN_W-1:0]   payload_len_reg;
    logic [TICK_W-1:0]   timeout_ticks_reg;

    logic                job_full;
    logic                job_empty;
    logic                job_push;
    logic                job_pop;
    logic [STATUS_W-1:0] push_status;
    logic [LW-1:0]       push_len;
    logic [JW-1:0]       pop_data;
    logic                emit_done;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [BYTE_W-1:0]   ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [BYTE_W-1:0]   ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_id_reg   <= EXPECTED_ID_RST;
            payload_len_reg   <= PAYLOAD_LEN_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_EXPECTED_ID) begin
                expected_id_reg <= cfg_data[ID_W-1:0];
            end
            if (cfg_index == CFG_PAYLOAD_LEN) begin
                payload_len_reg <= cfg_data[PLEN_W-1:0];
            end
            if (cfg_index == CFG_TIMEOUT_TICKS) begin
                timeout_ticks_reg <= cfg_data[TICK_W-1:0];
            end
        end
    end

    ssprx_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .op            (s_tuser),
        .byte_in       (s_tdata),
        .expected_id   (expected_id_reg),
        .payload_len   (payload_len_reg),
        .timeout_ticks (timeout_ticks_reg),
        .job_full      (job_full),
        .job_push      (job_push),
        .job_status    (push_status),
        .job_len       (push_len),
        .emit_done     (emit_done),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata)
    );

    ssprx_fifo #(
        .WIDTH (JW)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data ({push_len, push_status}),
        .pop       (job_pop),
        .pop_data  (pop_data),
        .full      (job_full),
        .empty     (job_empty)
    );

    ssprx_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ssprx_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (!job_empty),
        .job_status (pop_data[STATUS_W-1:0]),
        .job_len    (pop_data[JW-1:STATUS_W]),
        .job_pop    (job_pop),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .emit_done  (emit_done),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== rtl/ssprx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssprx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ssprx_fifo.sv =====
// Two-entry job queue between the frame parser and the result emitter.
// No dependencies.
module ssprx_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                mem_reg[wr_ptr_reg] <= push_data;
                wr_ptr_reg          <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);

    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !full)
        else $error("job pushed into full queue");
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !empty)
        else $error("job popped from empty queue");
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

// ===== rtl/ssprx_front.sv =====
// Frame parser: accepts stream items, tracks header, checksum and timer,
// fills the payload RAM and queues one job per finished frame. Uses ssprx_pkg.
module ssprx_front #(
    parameter int MAX_PAYLOAD = 16,
    localparam int LW = $clog2(MAX_PAYLOAD + 1),
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ssprx_pkg::OP_W-1:0]         op,
    input  logic [ssprx_pkg::BYTE_W-1:0]       byte_in,
    input  logic [ssprx_pkg::ID_W-1:0]         expected_id,
    input  logic [ssprx_pkg::PLEN_W-1:0]       payload_len,
    input  logic [ssprx_pkg::TICK_W-1:0]       timeout_ticks,
    input  logic                               job_full,
    output logic                               job_push,
    output logic [ssprx_pkg::STATUS_W-1:0]     job_status,
    output logic [LW-1:0]                      job_len,
    input  logic                               emit_done,
    output logic                               ram_we,
    output logic [AW-1:0]                      ram_waddr,
    output logic [ssprx_pkg::BYTE_W-1:0]       ram_wdata
);

    import ssprx_pkg::*;

    localparam int CW = $clog2(MAX_PAYLOAD + 5);

    logic              receiving_reg, receiving_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              mismatch_reg, mismatch_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic              ok_pending_reg, ok_pending_next;
    logic              accept;
    logic [LW-1:0]     len;
    logic              frame_end;

    always_comb begin
        if (payload_len == '0) begin
            len = LW'(1);
        end else if (32'(payload_len) > 32'(MAX_PAYLOAD)) begin
            len = LW'(MAX_PAYLOAD);
        end else begin
            len = LW'(payload_len);
        end
    end

    assign s_tready  = !job_full && !ok_pending_reg;
    assign accept    = s_tvalid && s_tready;
    assign frame_end = (32'(count_reg) >= 32'(len) + 32'd4);
    assign ram_waddr = AW'(count_reg - CW'(4));
    assign ram_wdata = byte_in;
    assign job_len   = len;

    always_comb begin
        receiving_next  = receiving_reg;
        count_next      = count_reg;
        mismatch_next   = mismatch_reg;
        sum_next        = sum_reg;
        tick_next       = tick_reg;
        ok_pending_next = ok_pending_reg && !emit_done;
        job_push        = 1'b0;
        job_status      = ST_OK;
        ram_we          = 1'b0;
        if (accept) begin
            priority if (op == OP_START) begin
                receiving_next = 1'b1;
                count_next     = '0;
                mismatch_next  = 1'b0;
                sum_next       = '0;
                tick_next      = '0;
            end else if (receiving_reg && op == OP_TICK) begin
                if (tick_reg >= timeout_ticks) begin
                    receiving_next = 1'b0;
                    job_push       = 1'b1;
                    job_status     = ST_TIMEOUT;
                end else begin
                    tick_next = tick_reg + TICK_W'(1);
                end
            end else if (receiving_reg && op == OP_BYTE) begin
                if (frame_end) begin
                    receiving_next = 1'b0;
                    job_push       = 1'b1;
                    priority if (mismatch_reg) begin
                        job_status = ST_MISMATCH;
                    end else if (byte_in != ~sum_reg) begin
                        job_status = ST_CHECKSUM;
                    end else begin
                        job_status      = ST_OK;
                        ok_pending_next = 1'b1;
                    end
                end else begin
                    count_next = count_reg + CW'(1);
                    if (count_reg < CW'(2)) begin
                        if (byte_in != SYNC_BYTE) begin
                            mismatch_next = 1'b1;
                        end
                    end else begin
                        sum_next = sum_reg + byte_in;
                        if (count_reg == CW'(2)) begin
                            if (byte_in != expected_id) begin
                                mismatch_next = 1'b1;
                            end
                        end else if (count_reg == CW'(3)) begin
                            if ({1'b0, byte_in} != 9'(len) + 9'd1) begin
                                mismatch_next = 1'b1;
                            end
                        end else begin
                            ram_we = 1'b1;
                        end
                    end
                end
            end else begin
                receiving_next = receiving_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            receiving_reg  <= 1'b0;
            count_reg      <= '0;
            mismatch_reg   <= 1'b0;
            sum_reg        <= '0;
            tick_reg       <= '0;
            ok_pending_reg <= 1'b0;
        end else begin
            receiving_reg  <= receiving_next;
            count_reg      <= count_next;
            mismatch_reg   <= mismatch_next;
            sum_reg        <= sum_next;
            tick_reg       <= tick_next;
            ok_pending_reg <= ok_pending_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        ok_pending_reg |-> !s_tready)
        else $error("item accepted while payload still being emitted");
    assert property (@(posedge aclk) disable iff (!aresetn)
        job_push |=> !receiving_reg)
        else $error("receiver still armed after frame result");
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (count_reg >= CW'(4)) && !frame_end)
        else $error("payload write outside payload positions");

endmodule

// ===== rtl/ssprx_back.sv =====
// Result emitter: takes queued jobs, sends a lone status item or walks the
// payload RAM into the output register. Uses ssprx_pkg.
module ssprx_back #(
    parameter int MAX_PAYLOAD = 16,
    localparam int LW = $clog2(MAX_PAYLOAD + 1),
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            job_valid,
    input  logic [ssprx_pkg::STATUS_W-1:0]  job_status,
    input  logic [LW-1:0]                   job_len,
    output logic                            job_pop,
    output logic [AW-1:0]                   ram_raddr,
    input  logic [ssprx_pkg::BYTE_W-1:0]    ram_rdata,
    output logic                            emit_done,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ssprx_pkg::BYTE_W-1:0]    m_tdata,
    output logic [ssprx_pkg::STATUS_W-1:0]  m_tuser,
    output logic                            m_tlast
);

    import ssprx_pkg::*;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_LOAD
    } bk_state_t;

    bk_state_t           state_reg;
    logic [AW-1:0]       idx_reg;
    logic [LW-1:0]       len_reg;
    logic                done_reg;
    logic                m_tvalid_reg;
    logic [BYTE_W-1:0]   m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;
    logic                m_tlast_reg;
    logic                out_free;
    logic                at_last;
    logic                load_out;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign at_last   = (32'(idx_reg) + 32'd1 >= 32'(len_reg));
    assign job_pop   = (state_reg == BK_IDLE) && job_valid &&
                       (job_status == ST_OK || out_free);
    assign load_out  = ((state_reg == BK_IDLE) && job_pop && (job_status != ST_OK)) ||
                       ((state_reg == BK_LOAD) && out_free);
    assign ram_raddr = idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            m_tvalid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                BK_IDLE: begin
                    if (job_pop) begin
                        if (job_status == ST_OK) begin
                            idx_reg   <= '0;
                            len_reg   <= job_len;
                            state_reg <= BK_READ;
                        end else begin
                            m_tdata_reg  <= '0;
                            m_tuser_reg  <= job_status;
                            m_tlast_reg  <= 1'b1;
                        end
                    end
                end
                BK_READ: begin
                    state_reg <= BK_LOAD;
                end
                BK_LOAD: begin
                    if (out_free) begin
                        m_tdata_reg  <= ram_rdata;
                        m_tuser_reg  <= ST_OK;
                        m_tlast_reg  <= at_last;
                        if (at_last) begin
                            done_reg  <= 1'b1;
                            state_reg <= BK_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + AW'(1);
                            state_reg <= BK_READ;
                        end
                    end
                end
                default: begin
                    state_reg <= BK_IDLE;
                end
            endcase
        end
    end

    assign emit_done = done_reg;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg != ST_OK |-> m_tlast_reg && m_tdata_reg == '0)
        else $error("error status item not alone or carries data");
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> m_tvalid_reg && m_tlast_reg && m_tuser_reg == ST_OK)
        else $error("payload run ended without final item");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != BK_IDLE |-> !job_pop)
        else $error("job taken while payload run in progress");

endmodule

// ===== dv/servo_status_packet_receiver_core_tb.sv =====
// Self-checking testbench for servo_status_packet_receiver_core: directed and random
// status frames, tick timeouts and register settings, with stalls on both streams.
// Depends on rtl/ssprx_pkg.sv and rtl/servo_status_packet_receiver_core.sv.
`timescale 1ns / 100ps

module servo_status_packet_receiver_core_tb;
    import ssprx_pkg::*;

    localparam logic [OP_W-1:0]      OP_RSVD  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RSVD = 2'd3;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [7:0]          data_byte;
        logic                last;
    } frame_result_t;

    class frame_checker;
        logic [ID_W-1:0]   reg_id      = EXPECTED_ID_RST;
        logic [PLEN_W-1:0] reg_len     = PAYLOAD_LEN_RST;
        logic [TICK_W-1:0] reg_timeout = TIMEOUT_TICKS_RST;
        bit                armed;
        int unsigned       pos;
        bit                bad_frame;
        bit [7:0]          sum;
        int unsigned       ticks;
        bit [7:0]          payload [MAX_PAYLOAD_DEF];
        frame_result_t     pending [$];
        int unsigned       errors;

        function int unsigned eff_len();
            if (reg_len == 0) return 1;
            if (reg_len > MAX_PAYLOAD_DEF) return MAX_PAYLOAD_DEF;
            return reg_len;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_EXPECTED_ID:   reg_id = val[ID_W-1:0];
                CFG_PAYLOAD_LEN:   reg_len = val[PLEN_W-1:0];
                CFG_TIMEOUT_TICKS: reg_timeout = val[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_item(logic [OP_W-1:0] op, logic [7:0] b);
            int unsigned len;
            int unsigned i;
            len = eff_len();
            if (op == OP_START) begin
                armed = 1'b1;
                pos = 0;
                bad_frame = 1'b0;
                sum = 8'h00;
                ticks = 0;
                return;
            end
            if (!armed) return;
            if (op == OP_TICK) begin
                if (ticks >= reg_timeout) begin
                    armed = 1'b0;
                    pending.insert(pending.size(),
                                   frame_result_t'{ST_TIMEOUT, 8'h00, 1'b1});
                end else begin
                    ticks++;
                end
                return;
            end
            if (op != OP_BYTE) return;
            if (pos >= len + 4) begin
                armed = 1'b0;
                if (bad_frame)
                    pending.insert(pending.size(),
                                   frame_result_t'{ST_MISMATCH, 8'h00, 1'b1});
                else if (b != ~sum)
                    pending.insert(pending.size(),
                                   frame_result_t'{ST_CHECKSUM, 8'h00, 1'b1});
                else
                    for (i = 0; i < len; i++)
                        pending.insert(pending.size(),
                                       frame_result_t'{ST_OK, payload[i], i + 1 == len});
                return;
            end
            if (pos < 2) begin
                if (b != SYNC_BYTE) bad_frame = 1'b1;
            end else begin
                sum += b;
                if (pos == 2) begin
                    if (b != reg_id) bad_frame = 1'b1;
                end else if (pos == 3) begin
                    if (b != len + 1) bad_frame = 1'b1;
                end else begin
                    payload[pos - 4] = b;
                end
            end
            pos++;
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 200) $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(frame_result_t got);
            frame_result_t want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction status=%0d data=%02h last=%0b",
                                          got.status, got.data_byte, got.last));
                return;
            end
            want = pending.pop_front();
            if (got.status != want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.data_byte != want.data_byte)
                report_mismatch($sformatf("data_byte %02h, want %02h",
                                          got.data_byte, want.data_byte));
            if (got.last != want.last)
                report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] byte_in
    logic [OP_W-1:0]       s_tuser;   // [1:0] op
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;   // [7:0] data_byte
    logic [STATUS_W-1:0]   m_tuser;   // [1:0] status
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    frame_checker sb = new();
    int unsigned  items_sent = 0;
    int unsigned  burst_left = 0;
    int unsigned  cycle_cnt = 0;
    int unsigned  stall_mode = 0;
    int unsigned  stall_left = 0;
    int unsigned  stall_phase = 0;

    servo_status_packet_receiver_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end else begin
            stall_left--;
        end
        stall_phase++;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= (stall_phase % 5 < 2);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(frame_result_t'({m_tuser, m_tdata, m_tlast}));
    end

    task automatic send_item(logic [OP_W-1:0] op, logic [7:0] b);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.take_item(op, b);
        items_sent++;
    endtask

    task automatic send_bytes(logic [7:0] q[$]);
        int i;
        for (i = 0; i < q.size(); i++) send_item(OP_BYTE, q[i]);
    endtask

    function automatic void seal(ref logic [7:0] q[$]);
        logic [7:0] acc;
        int i;
        acc = 8'h00;
        for (i = 2; i < q.size(); i++) acc += q[i];
        q.insert(q.size(), ~acc);
    endfunction

    // Hold input until every expected transaction is out and the block settles.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic load_settings(logic [7:0] id, logic [4:0] len, logic [15:0] timeout);
        write_register(CFG_EXPECTED_ID, {8'h00, id});
        write_register(CFG_PAYLOAD_LEN, {11'h000, len});
        write_register(CFG_TIMEOUT_TICKS, timeout);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_frame();
        logic [7:0]      frame[$];
        logic [OP_W-1:0] op;
        int unsigned     len;
        int unsigned     kind;
        int unsigned     cut;
        int              i;
        len = sb.eff_len();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                op = ($urandom_range(0, 2) == 0) ? OP_BYTE
                   : ($urandom_range(0, 1) ? OP_TICK : OP_RSVD);
                send_item(op, 8'($urandom_range(0, 255)));
            end
        end
        frame = {SYNC_BYTE, SYNC_BYTE, sb.reg_id, 8'(len + 1)};
        repeat (len) frame.insert(frame.size(), 8'($urandom_range(0, 255)));
        seal(frame);
        kind = $urandom_range(0, 99);
        if (kind < 8)
            frame[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
        else if (kind < 16)
            frame[2] ^= 8'($urandom_range(1, 255));
        else if (kind < 24)
            frame[3] ^= 8'($urandom_range(1, 255));
        if ($urandom_range(0, 9) == 0)
            frame[frame.size() - 1] ^= 8'($urandom_range(1, 255));
        cut = (kind >= 24 && kind < 36) ? $urandom_range(0, frame.size() - 1) : frame.size();
        send_item(OP_START, 8'($urandom_range(0, 255)));
        for (i = 0; i < cut; i++) begin
            if ($urandom_range(0, 19) == 0) send_item(OP_TICK, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 39) == 0) send_item(OP_RSVD, 8'($urandom_range(0, 255)));
            send_item(OP_BYTE, frame[i]);
        end
        if (cut < frame.size() && sb.reg_timeout <= 40)
            repeat (sb.reg_timeout + 1) send_item(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_frames(int unsigned n);
        int unsigned stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            send_random_frame();
            if ($urandom_range(0, 24) == 0) drain();
        end
    endtask

    initial begin : stimulus
        logic [7:0] frame[$];
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tuser   = OP_START;
        cfg_valid = 1'b0;
        cfg_index = CFG_EXPECTED_ID;
        cfg_data  = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(OP_BYTE, 8'hFF);
        send_item(OP_TICK, 8'h00);
        send_item(OP_RSVD, 8'h5A);

        frame = {SYNC_BYTE, SYNC_BYTE, EXPECTED_ID_RST, 8'(PAYLOAD_LEN_RST + 1), 8'h00, 8'hFF};
        seal(frame);
        send_item(OP_START, 8'h00);
        send_bytes(frame);

        // Abandon a partial frame, then close a fresh one with a bad checksum.
        send_item(OP_START, 8'hFF);
        send_item(OP_BYTE, SYNC_BYTE);
        send_item(OP_BYTE, SYNC_BYTE);
        frame = {SYNC_BYTE, SYNC_BYTE, EXPECTED_ID_RST, 8'(PAYLOAD_LEN_RST + 1), 8'h12, 8'h34};
        seal(frame);
        frame[frame.size() - 1] ^= 8'h80;
        send_item(OP_START, 8'h00);
        send_bytes(frame);
        drain();

        write_register(CFG_TIMEOUT_TICKS, 16'h0000);
        cfg_valid <= 1'b0;
        send_item(OP_START, 8'h00);
        send_item(OP_TICK, 8'h00);
        drain();

        load_settings(8'd0, 5'd1, 16'hFFFF);
        run_frames(80);
        drain();
        load_settings(8'd253, 5'd16, 16'd7);
        run_frames(50);
        drain();
        load_settings(8'h5A, 5'd0, 16'd12);
        run_frames(80);
        drain();
        load_settings(8'($urandom_range(0, 253)), 5'd31, 16'd0);
        run_frames(40);
        drain();
        load_settings(8'($urandom_range(0, 253)), 5'($urandom_range(1, 4)),
                      16'($urandom_range(2, 30)));
        run_frames(90);
        drain();
        write_register(CFG_RSVD, 16'($urandom_range(0, 65535)));
        load_settings(8'($urandom_range(0, 253)), 5'd3, 16'd1000);
        run_frames(80);
        drain();

        if (sb.pending.size() != 0)
            sb.report_mismatch($sformatf("%0d expected transactions never arrived",
                                         sb.pending.size()));
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
